### hdl/pfpc_pkg.sv
// Package with shared constants, types and CRC helpers for the pose frame parser.
`timescale 1ns / 1ps
package pfpc_pkg;

  localparam int unsigned BufDepth = 32;

  localparam logic [7:0]  HdrV1 = 8'h5C;
  localparam logic [7:0]  HdrV2 = 8'h5D;
  localparam logic [4:0]  LenV1 = 5'd14;
  localparam logic [4:0]  LenV2 = 5'd28;
  localparam logic [7:0]  Crc8Init = 8'hFF;
  localparam logic [7:0]  Crc8Poly = 8'h8C;
  localparam logic [15:0] Crc16Init = 16'hFFFF;
  localparam logic [15:0] Crc16Poly = 16'h8408;
  localparam logic [30:0] LimitXy = 31'h447A0000;
  localparam logic [30:0] LimitZ = 31'h49742400;

  localparam logic CfgVersion = 1'b0;
  localparam logic CfgFlagMask = 1'b1;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } mem_req_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ Crc8Poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ Crc16Poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic values_ok(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return (x[30:0] < LimitXy) && (y[30:0] < LimitXy) && (z[30:0] < LimitZ);
  endfunction

endpackage

### hdl/pfpc_buf.sv
// Resync byte buffer: one write port and one registered read port.
`timescale 1ns / 1ps
module pfpc_buf #(
  parameter int unsigned BUF_DEPTH = pfpc_pkg::BufDepth,
  parameter int unsigned AW = $clog2(BUF_DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [BUF_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pose_frame_parser_crc.sv
// Top level of the dual format pose frame parser with CRC8 and CRC16 checks.
//   channel | direction | handshake                 | payload
//   input   | in        | in_valid_i / in_ready_o   | rx_byte_i
//   output  | out       | out_valid_o / out_ready_i | frame_done_o .. format_fail_count_o
//   config  | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
// Each beat goes through ST_WR and ST_CHECK, then one scan pass per frame candidate, one
// buffered byte per cycle through the buffer read port, with ST_CHECK before each pass.
// The buffer needs no clearing pass after reset.
// Input is stalled from acceptance until the result is loaded into the output register.
`timescale 1ns / 1ps
module pose_frame_parser_crc #(
  parameter int unsigned BUF_DEPTH = pfpc_pkg::BufDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_done_o,
  output logic        frame_is_v2_o,
  output logic        pose_ok_o,
  output logic        session_changed_o,
  output logic [31:0] x_bits_o,
  output logic [31:0] y_bits_o,
  output logic [31:0] z_bits_o,
  output logic [15:0] seq_number_o,
  output logic [31:0] session_word_o,
  output logic [31:0] stamp_ms_o,
  output logic [4:0]  crc_fail_count_o,
  output logic [4:0]  format_fail_count_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned FW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WR, ST_CHECK, ST_SCAN, ST_OUT
  } state_e;

  function automatic logic [AW-1:0] wrap(logic [AW-1:0] base, logic [FW-1:0] off);
    logic [FW:0] s;
    s = {{(FW+1-AW){1'b0}}, base} + {1'b0, off};
    if (s >= (FW+1)'(BUF_DEPTH)) begin
      s = s - (FW+1)'(BUF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_e          state_q;
  logic [7:0]      ver_cfg_q, mask_cfg_q;
  logic [AW-1:0]   head_q;
  logic [FW-1:0]   fill_q;
  logic [31:0]     last_sess_q;
  logic [7:0]      byte_q;
  logic [4:0]      k_q;
  logic            v2_q;
  logic [7:0]      crc8_q, crc_lo_q;
  logic [15:0]     crc16_q;
  logic [111:0]    meta_q;
  logic [95:0]     xyz_q;
  logic [4:0]      crc_cnt_q, fmt_cnt_q;
  logic            r_done_q, r_v2_q, r_ok_q, r_chg_q;
  logic [95:0]     r_xyz_q;
  logic [15:0]     r_seq_q;
  logic [31:0]     r_sess_q, r_stamp_q;
  logic            out_valid_q;

  pfpc_pkg::mem_req_t req;
  logic [7:0]      rdata;

  pfpc_buf #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_buf (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .waddr_i (req.waddr[AW-1:0]),
    .wdata_i (req.wdata),
    .raddr_i (req.raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  logic [4:0]  xoff, need;
  logic [4:0]  xi;
  logic [31:0] sess_w;

  always_comb begin
    req = '0;
    req.wdata = byte_q;
    req.waddr = 8'(wrap(head_q, fill_q));
    req.we = (state_q == ST_WR);
    req.raddr = 8'(wrap(head_q, FW'(k_q + 5'd1)));
    if (state_q == ST_CHECK) begin
      req.raddr = 8'(head_q);
    end
    xoff = v2_q ? 5'd14 : 5'd1;
    need = v2_q ? pfpc_pkg::LenV2 : pfpc_pkg::LenV1;
    xi = k_q - xoff;
    sess_w = meta_q[79:48];
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ver_cfg_q   <= 8'd2;
      mask_cfg_q  <= 8'd7;
      head_q      <= '0;
      fill_q      <= '0;
      last_sess_q <= '0;
      out_valid_q <= 1'b0;
      crc_cnt_q   <= '0;
      fmt_cnt_q   <= '0;
      r_done_q    <= 1'b0;
      k_q         <= '0;
      v2_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pfpc_pkg::CfgVersion:  ver_cfg_q <= cfg_wdata_i;
          pfpc_pkg::CfgFlagMask: mask_cfg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            byte_q    <= rx_byte_i;
            crc_cnt_q <= '0;
            r_done_q  <= 1'b0;
            r_v2_q    <= 1'b0;
            r_ok_q    <= 1'b0;
            r_chg_q   <= 1'b0;
            r_xyz_q   <= '0;
            r_seq_q   <= '0;
            r_sess_q  <= '0;
            r_stamp_q <= '0;
            if (fill_q == FW'(BUF_DEPTH)) begin
              fmt_cnt_q <= 5'd1;
              head_q    <= wrap(head_q, FW'(1));
              fill_q    <= fill_q - FW'(1);
            end else begin
              fmt_cnt_q <= '0;
            end
            state_q <= ST_WR;
          end
        end
        ST_WR: begin
          fill_q  <= fill_q + FW'(1);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          k_q <= '0;
          state_q <= (fill_q == '0) ? ST_OUT : ST_SCAN;
        end
        ST_SCAN: begin
          k_q <= k_q + 5'd1;
          if (k_q < 5'd13) begin
            crc8_q <= pfpc_pkg::crc8_byte((k_q == '0) ? pfpc_pkg::Crc8Init : crc8_q, rdata);
          end
          if (k_q < 5'd26) begin
            crc16_q <= pfpc_pkg::crc16_byte((k_q == '0) ? pfpc_pkg::Crc16Init : crc16_q,
                                            rdata);
          end
          if (k_q == 5'd26) begin
            crc_lo_q <= rdata;
          end
          if (k_q < 5'd14) begin
            meta_q[8*k_q[3:0] +: 8] <= rdata;
          end
          if (k_q >= xoff && xi < 5'd12) begin
            xyz_q[8*xi[3:0] +: 8] <= rdata;
          end
          priority if (k_q == '0) begin
            priority if (rdata == pfpc_pkg::HdrV1) begin
              v2_q <= 1'b0;
              if (fill_q < FW'(pfpc_pkg::LenV1)) begin
                state_q <= ST_OUT;
              end
            end else if (rdata == pfpc_pkg::HdrV2) begin
              v2_q <= 1'b1;
              if (fill_q < FW'(3)) begin
                state_q <= ST_OUT;
              end
            end else begin
              if (fmt_cnt_q != 5'd31) fmt_cnt_q <= fmt_cnt_q + 5'd1;
              head_q  <= wrap(head_q, FW'(1));
              fill_q  <= fill_q - FW'(1);
              state_q <= ST_CHECK;
            end
          end else if (v2_q && k_q == 5'd2) begin
            if (meta_q[15:8] != ver_cfg_q || rdata != 8'(pfpc_pkg::LenV2)) begin
              if (fmt_cnt_q != 5'd31) fmt_cnt_q <= fmt_cnt_q + 5'd1;
              head_q  <= wrap(head_q, FW'(1));
              fill_q  <= fill_q - FW'(1);
              state_q <= ST_CHECK;
            end else if (fill_q < FW'(pfpc_pkg::LenV2)) begin
              state_q <= ST_OUT;
            end
          end else if (k_q == need - 5'd1) begin
            state_q <= ST_CHECK;
            if (v2_q ? (crc16_q == {rdata, crc_lo_q}) : (crc8_q == rdata)) begin
              head_q    <= wrap(head_q, FW'(need));
              fill_q    <= fill_q - FW'(need);
              r_done_q  <= 1'b1;
              r_v2_q    <= v2_q;
              r_xyz_q   <= xyz_q;
              if (v2_q) begin
                r_ok_q    <= ((meta_q[31:24] & mask_cfg_q) == mask_cfg_q) &&
                             pfpc_pkg::values_ok(xyz_q[31:0], xyz_q[63:32], xyz_q[95:64]);
                r_chg_q   <= (sess_w != last_sess_q) && (last_sess_q != '0);
                last_sess_q <= sess_w;
                r_seq_q   <= meta_q[47:32];
                r_sess_q  <= sess_w;
                r_stamp_q <= meta_q[111:80];
              end else begin
                r_ok_q    <= pfpc_pkg::values_ok(xyz_q[31:0], xyz_q[63:32], xyz_q[95:64]);
                r_chg_q   <= (last_sess_q != '0);
                last_sess_q <= '0;
                r_seq_q   <= '0;
                r_sess_q  <= '0;
                r_stamp_q <= '0;
              end
            end else begin
              if (crc_cnt_q != 5'd31) crc_cnt_q <= crc_cnt_q + 5'd1;
              head_q <= wrap(head_q, FW'(1));
              fill_q <= fill_q - FW'(1);
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            frame_done_o        <= r_done_q;
            frame_is_v2_o       <= r_v2_q;
            pose_ok_o           <= r_ok_q;
            session_changed_o   <= r_chg_q;
            x_bits_o            <= r_xyz_q[31:0];
            y_bits_o            <= r_xyz_q[63:32];
            z_bits_o            <= r_xyz_q[95:64];
            seq_number_o        <= r_seq_q;
            session_word_o      <= r_sess_q;
            stamp_ms_o          <= r_stamp_q;
            crc_fail_count_o    <= crc_cnt_q;
            format_fail_count_o <= fmt_cnt_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
